[sv/ecg_pkg.sv]
// shared codes, widths and types for the easing curve generator
package ecg_pkg;

    // fixed stream and register port widths
    localparam int DATA_W    = 16;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b1;

    // curve shape codes (cubic and quartic sit between quadratic and quintic)
    localparam logic [2:0] SHAPE_QUAD    = 3'd1;
    localparam logic [2:0] SHAPE_QUINTIC = 3'd4;
    localparam logic [2:0] SHAPE_SINE    = 3'd5;

    // direction codes (ease-in is every other code)
    localparam logic [1:0] DIR_OUT   = 2'd1;
    localparam logic [1:0] DIR_INOUT = 2'd2;

    // active curve selection
    typedef struct packed {
        logic [2:0] shape;
        logic [1:0] direction;
    } cfg_t;

endpackage

[sv/ecg_front.sv]
// input stage: saturation of the time fraction and operand selection
module ecg_front #(
    parameter int FRAC_BITS = 15
) (
    input  logic                        clk,
    input  logic                        en,
    input  ecg_pkg::cfg_t               cfg,
    input  logic [ecg_pkg::DATA_W-1:0]  time_in,
    output logic [FRAC_BITS:0]          t_out,
    output logic [FRAC_BITS:0]          s_out,
    output logic [FRAC_BITS:0]          u_out,
    output logic                        half_out
);

    localparam int F  = FRAC_BITS;
    localparam int TW = (F + 1 > ecg_pkg::DATA_W) ? F + 1 : ecg_pkg::DATA_W;
    localparam logic [F+1:0] ONE_X  = (F + 2)'(1) << F;
    localparam logic [F+1:0] HALF_X = (F + 2)'(1) << (F - 1);

    logic [TW-1:0] in_ext;
    logic [F:0]    t_sat;
    logic [F+1:0]  t_x;
    logic [F+1:0]  two_t;
    logic [F+1:0]  one_minus_t;
    logic [F+1:0]  two_one_minus_t;
    logic          half;
    logic [F+1:0]  s_x;
    logic [F+1:0]  u_x;

    logic [F:0]    t_reg;
    logic [F:0]    s_reg;
    logic [F:0]    u_reg;
    logic          half_reg;

    // values above one are taken as one
    always_comb
    begin
        in_ext = TW'(time_in);
        if (in_ext > TW'(ONE_X))
        begin
            t_sat = ONE_X[F:0];
        end
        else
        begin
            t_sat = in_ext[F:0];
        end
    end

    // power operand and sine argument for each direction
    always_comb
    begin
        t_x             = (F + 2)'(t_sat);
        two_t           = t_x << 1;
        one_minus_t     = ONE_X - t_x;
        two_one_minus_t = one_minus_t << 1;
        half            = (t_x < HALF_X);
        case (cfg.direction)
            ecg_pkg::DIR_OUT:
            begin
                s_x = one_minus_t;
                u_x = t_x;
            end
            ecg_pkg::DIR_INOUT:
            begin
                if (half)
                begin
                    s_x = two_t;
                    u_x = ONE_X - two_t;
                end
                else
                begin
                    s_x = two_one_minus_t;
                    u_x = two_t - ONE_X;
                end
            end
            default:
            begin
                s_x = t_x;
                u_x = one_minus_t;
            end
        endcase
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= t_sat;
            s_reg    <= s_x[F:0];
            u_reg    <= u_x[F:0];
            half_reg <= half;
        end
    end

    assign t_out    = t_reg;
    assign s_out    = s_reg;
    assign u_out    = u_reg;
    assign half_out = half_reg;

endmodule

[sv/ecg_power.sv]
// four-stage power pipeline: at most one rounded fixed-point multiply per stage
module ecg_power #(
    parameter int FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               en,
    input  ecg_pkg::cfg_t      cfg,
    input  logic [FRAC_BITS:0] s_in,
    output logic [FRAC_BITS:0] p_out
);

    localparam int F     = FRAC_BITS;
    localparam int PW    = 2 * F + 2;
    localparam int NSTG  = 4;
    localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);

    logic [2:0] nmul;
    logic [F:0] p_in [0:NSTG];
    logic [F:0] s_in_arr [0:NSTG-1];
    logic [F:0] p_reg [1:NSTG];
    logic [F:0] s_reg [1:NSTG-1];

    // number of multiplies: exponent minus one
    always_comb
    begin
        if (cfg.shape inside {[ecg_pkg::SHAPE_QUAD:ecg_pkg::SHAPE_QUINTIC]})
        begin
            nmul = cfg.shape;
        end
        else
        begin
            nmul = 3'd0;
        end
    end

    assign p_in[0]     = s_in;
    assign s_in_arr[0] = s_in;

    for (genvar j = 1; j <= NSTG; j++)
    begin : g_stage
        logic [PW-1:0] prod;
        logic [PW-1:0] prod_rnd;
        logic [F:0]    p_next;

        // p * s rounded to nearest, or pass through once the exponent is reached
        assign prod     = PW'(p_in[j-1]) * PW'(s_in_arr[j-1]);
        assign prod_rnd = prod + HALF_P;

        always_comb
        begin
            if (3'(j) <= nmul)
            begin
                p_next = prod_rnd[2*F:F];
            end
            else
            begin
                p_next = p_in[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[j] <= p_next;
            end
        end

        assign p_in[j] = p_reg[j];

        // operand travels alongside the partial power
        if (j < NSTG)
        begin : g_oper
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    s_reg[j] <= s_in_arr[j-1];
                end
            end
            assign s_in_arr[j] = s_reg[j];
        end
    end

    assign p_out = p_reg[NSTG];

endmodule

[sv/ecg_sine.sv]
// four-stage quarter-wave sine: position, table read, interpolation multiply, sum
module ecg_sine #(
    parameter int FRAC_BITS        = 15,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               en,
    input  logic [FRAC_BITS:0] u_in,
    output logic [FRAC_BITS:0] s_out
);

    localparam int F   = FRAC_BITS;
    localparam int D   = SINE_TABLE_DEPTH;
    localparam int AW  = $clog2(D + 1);
    localparam int QW  = F + AW;
    localparam int MW  = 2 * F + 2;
    localparam int SH  = 30 - F;
    localparam logic [63:0] HPI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] ONE64   = 64'd1 << F;
    localparam logic [F:0]  ONE     = {1'b1, {F{1'b0}}};
    localparam logic [MW-1:0] HALF_M = MW'(1) << (F - 1);

    // q30 product rounded to nearest
    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = (a * b + (Q30_ONE >> 1)) >> 30;
        return r;
    endfunction

    // taylor series through the x^13 term, clamped to one
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_q30(x, x);
        sum  = x;
        term = mul_q30(x, x2);
        term = (term + 64'd3) / 64'd6;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = mul_q30(term, x2);
        term = (term + 64'd10) / 64'd20;
        sum  = sum + term;
        term = mul_q30(term, x2);
        term = (term + 64'd21) / 64'd42;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = mul_q30(term, x2);
        term = (term + 64'd36) / 64'd72;
        sum  = sum + term;
        term = mul_q30(term, x2);
        term = (term + 64'd55) / 64'd110;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = mul_q30(term, x2);
        term = (term + 64'd78) / 64'd156;
        sum  = sum + term;
        return (sum > Q30_ONE) ? Q30_ONE : sum;
    endfunction

    logic [F:0] sine_rom [0:D];

    // table contents fixed at elaboration, last entry forced to one
    for (genvar k = 0; k <= D; k++)
    begin : g_rom
        localparam logic [63:0] XK = (HPI_Q30 * 64'(k) + 64'(D / 2)) / 64'(D);
        localparam logic [63:0] SK = sine_q30(XK);
        localparam logic [63:0] VK = (SK + (64'd1 << (SH - 1))) >> SH;
        localparam logic [63:0] EK = (k == D || VK > ONE64) ? ONE64 : VK;
        assign sine_rom[k] = EK[F:0];
    end

    logic [QW-1:0] pos;
    logic [AW-1:0] k_reg;
    logic [F-1:0]  fa_reg;
    logic [AW-1:0] kr;
    logic          end_a;
    logic [F:0]    t0_reg;
    logic [F:0]    t1_reg;
    logic [F-1:0]  fb_reg;
    logic          endb_reg;
    logic [F:0]    diff;
    logic [MW-1:0] prod;
    logic [MW-1:0] prod_rnd;
    logic [F:0]    interp_reg;
    logic [F:0]    t0c_reg;
    logic          endc_reg;
    logic [F+1:0]  sum;
    logic [F:0]    s_next;
    logic [F:0]    s_reg;

    // stage a: table position u * depth
    assign pos = QW'(u_in) * QW'(D);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg  <= pos[QW-1:F];
            fa_reg <= pos[F-1:0];
        end
    end

    // stage b: read the two neighboring entries
    assign end_a = (k_reg == AW'(D));
    assign kr    = end_a ? AW'(D - 1) : k_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg   <= sine_rom[kr];
            t1_reg   <= sine_rom[kr + AW'(1)];
            fb_reg   <= fa_reg;
            endb_reg <= end_a;
        end
    end

    // stage c: interpolation product rounded to nearest
    assign diff     = t1_reg - t0_reg;
    assign prod     = MW'(diff) * MW'(fb_reg);
    assign prod_rnd = prod + HALF_M;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            interp_reg <= prod_rnd[2*F:F];
            t0c_reg    <= t0_reg;
            endc_reg   <= endb_reg;
        end
    end

    // stage d: base plus interpolated step, one at the end of the table
    always_comb
    begin
        sum = (F + 2)'(t0c_reg) + (F + 2)'(interp_reg);
        if (endc_reg)
        begin
            s_next = ONE;
        end
        else
        begin
            s_next = sum[F:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
        end
    end

    assign s_out = s_reg;

endmodule

[sv/easing_curve_generator.sv]
// easing curve generator top level: configuration, pipeline control and output stage
// an input passes the front stage, power or sine stages and output register in order
// throughput: one item per cycle unless the skid is full; slowest stage is one 16x16 power multiply
// a two-entry output stage (register plus skid) keeps input ready while a result waits
// reset clears shape and direction to linear ease-in and empties all valid bits
// the sine table is constant, so no clearing pass follows reset
module easing_curve_generator #(
    parameter int FRAC_BITS        = 15,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ecg_pkg::DATA_W-1:0]     s_axis_tdata,   // [15:0] time_fraction
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ecg_pkg::DATA_W-1:0]     m_axis_tdata,   // [15:0] eased_value
    input  logic                           cfg_we,
    input  logic [ecg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ecg_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int F     = FRAC_BITS;
    localparam int NPIPE = 5;
    localparam int OW    = (F + 2 > ecg_pkg::DATA_W) ? F + 2 : ecg_pkg::DATA_W;
    localparam logic [F+1:0] ONE_X = (F + 2)'(1) << F;

    ecg_pkg::cfg_t cfg_reg;

    logic              en;
    logic [NPIPE:1]    v_reg;
    logic [F:0]        t1;
    logic [F:0]        s1;
    logic [F:0]        u1;
    logic              half1;
    logic [F:0]        t_reg [2:NPIPE];
    logic              half_reg [2:NPIPE];
    logic [F:0]        p5;
    logic [F:0]        sine5;

    logic [F+1:0]      p_x;
    logic [F+1:0]      sn_x;
    logic [F+1:0]      p_half;
    logic [F+1:0]      r;
    logic [OW-1:0]     r_ext;
    logic [ecg_pkg::DATA_W-1:0] res;

    logic                       out_valid_reg;
    logic [ecg_pkg::DATA_W-1:0] out_data_reg;
    logic                       skid_valid_reg;
    logic [ecg_pkg::DATA_W-1:0] skid_data_reg;
    logic                       incoming;

    // configuration registers, out-of-list indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ecg_pkg::REG_SHAPE:     cfg_reg.shape     <= cfg_wdata;
                ecg_pkg::REG_DIRECTION: cfg_reg.direction <= cfg_wdata[1:0];
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // the pipeline advances while the skid entry is empty
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NPIPE-1:1], s_axis_tvalid};
        end
    end

    ecg_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .time_in  (s_axis_tdata),
        .t_out    (t1),
        .s_out    (s1),
        .u_out    (u1),
        .half_out (half1)
    );

    ecg_power #(
        .FRAC_BITS (FRAC_BITS)
    ) u_power (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .s_in  (s1),
        .p_out (p5)
    );

    ecg_sine #(
        .FRAC_BITS        (FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .clk   (clk),
        .en    (en),
        .u_in  (u1),
        .s_out (sine5)
    );

    // time and half flag follow the curve pipelines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[2]    <= t1;
            half_reg[2] <= half1;
            for (int i = 3; i <= NPIPE; i++)
            begin
                t_reg[i]    <= t_reg[i-1];
                half_reg[i] <= half_reg[i-1];
            end
        end
    end

    // final mirroring and halving per direction
    always_comb
    begin
        p_x    = (F + 2)'(p5);
        sn_x   = (F + 2)'(sine5);
        p_half = (p_x + (F + 2)'(1)) >> 1;
        if (cfg_reg.shape inside {[ecg_pkg::SHAPE_QUAD:ecg_pkg::SHAPE_QUINTIC]})
        begin
            case (cfg_reg.direction)
                ecg_pkg::DIR_OUT:   r = ONE_X - p_x;
                ecg_pkg::DIR_INOUT: r = half_reg[NPIPE] ? p_half : ONE_X - p_half;
                default:            r = p_x;
            endcase
        end
        else if (cfg_reg.shape == ecg_pkg::SHAPE_SINE)
        begin
            case (cfg_reg.direction)
                ecg_pkg::DIR_OUT:   r = sn_x;
                ecg_pkg::DIR_INOUT:
                begin
                    if (half_reg[NPIPE])
                    begin
                        r = (ONE_X - sn_x + (F + 2)'(1)) >> 1;
                    end
                    else
                    begin
                        r = (ONE_X + sn_x + (F + 2)'(1)) >> 1;
                    end
                end
                default:            r = ONE_X - sn_x;
            endcase
        end
        else
        begin
            r = (F + 2)'(t_reg[NPIPE]);
        end
        r_ext = OW'(r);
        res   = r_ext[ecg_pkg::DATA_W-1:0];
    end

    // output register with a skid entry behind it
    assign incoming = en && v_reg[NPIPE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= incoming;
            end
        end
        else if (incoming)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (incoming)
            begin
                out_data_reg <= res;
            end
        end
        else if (incoming)
        begin
            skid_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
